// File: rtl/actr_pkg.sv
// Shared types and AES-128 round functions for the counter-mode block unit.
// No dependencies. Used by the round cells, the final cell and the top level.
package actr_pkg;

    // 16-byte AES block, byte 0 in the top bits (index = row + 4 * column)
    typedef logic [0:15][7:0] blk_t;

    // Payload carried from one pipeline cell to the next
    typedef struct packed {
        blk_t       state;   // cipher state after the previous round
        blk_t       rkey;    // round key used by the previous round
        logic [7:0] rcon;    // round constant for the next key step
        blk_t       data;    // data block waiting for its keystream
    } stage_t;

    localparam logic [7:0] RCON_FIRST = 8'h01;
    localparam logic [7:0] GF_POLY    = 8'h1b;

    localparam logic [7:0] SBOX [0:255] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // Multiply by x in GF(2^8)
    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
    endfunction

    // SubBytes followed by ShiftRows
    function automatic blk_t sub_shift(input blk_t s);
        blk_t t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[r + 4 * c] = SBOX[s[r + 4 * ((c + r) & 3)]];
            end
        end
        return t;
    endfunction

    function automatic blk_t mix_columns(input blk_t s);
        blk_t       t;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = s[4 * c];
            a1 = s[4 * c + 1];
            a2 = s[4 * c + 2];
            a3 = s[4 * c + 3];
            t[4 * c]     = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            t[4 * c + 1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            t[4 * c + 2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            t[4 * c + 3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        return t;
    endfunction

    // One step of the AES-128 key schedule
    function automatic blk_t key_step(input blk_t rk, input logic [7:0] rc);
        blk_t       k;
        logic [7:0] t0, t1, t2, t3;
        k  = rk;
        t0 = SBOX[rk[13]] ^ rc;
        t1 = SBOX[rk[14]];
        t2 = SBOX[rk[15]];
        t3 = SBOX[rk[12]];
        for (int c = 0; c < 4; c++) begin
            k[4 * c]     = k[4 * c] ^ t0;
            t0           = k[4 * c];
            k[4 * c + 1] = k[4 * c + 1] ^ t1;
            t1           = k[4 * c + 1];
            k[4 * c + 2] = k[4 * c + 2] ^ t2;
            t2           = k[4 * c + 2];
            k[4 * c + 3] = k[4 * c + 3] ^ t3;
            t3           = k[4 * c + 3];
        end
        return k;
    endfunction

endpackage

// File: rtl/actr_round_cell.sv
// One full AES round with its key expansion step, registered.
// Depends on actr_pkg.
module actr_round_cell
    import actr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   adv,
    input  logic   in_valid,
    input  stage_t in_stage,
    output logic   out_valid,
    output stage_t out_stage
);

    logic   valid_reg;
    stage_t stage_reg;
    stage_t stage_next;
    blk_t   rkey_next;

    // SubBytes, ShiftRows, MixColumns, AddRoundKey; key advances alongside
    always_comb
    begin
        rkey_next        = key_step(in_stage.rkey, in_stage.rcon);
        stage_next.state = mix_columns(sub_shift(in_stage.state)) ^ rkey_next;
        stage_next.rkey  = rkey_next;
        stage_next.rcon  = xtime(in_stage.rcon);
        stage_next.data  = in_stage.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

// File: rtl/actr_final_cell.sv
// Last AES round (no MixColumns), keystream XOR and the output register.
// Depends on actr_pkg.
module actr_final_cell
    import actr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         adv,
    input  logic         in_valid,
    input  stage_t       in_stage,
    output logic         out_valid,
    output logic [127:0] out_data
);

    logic         valid_reg;
    blk_t         result_reg;
    blk_t         result_next;
    blk_t         keystream;

    // Final round, then mix the keystream into the data
    always_comb
    begin
        keystream   = sub_shift(in_stage.state) ^ key_step(in_stage.rkey, in_stage.rcon);
        result_next = in_stage.data ^ keystream;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = result_reg;

endmodule

// File: rtl/aes128_ctr_block_unit.sv
// Top level of the AES-128 counter-mode block unit: config registers, counter,
// key whitening stage and the chain of round cells. Depends on actr_pkg,
// actr_round_cell and actr_final_cell.
//
// Usage:
//   Input stream (s_*): one 16-byte data block per transfer; s_tuser set marks
//   the first block of a message and reloads the block counter from
//   counter_start before that block is used.
//   Output stream (m_*): data XOR keystream, one transfer per input transfer,
//   in order.
//   Config channel (cfg_*): cfg_ready is always high; index 0..4 selects
//   key_high, key_low, nonce_high, nonce_low, counter_start. Other indexes are
//   ignored. Write only while no blocks are in flight.
//   Throughput: one block per cycle while the output is not stalled. The
//   pipeline is one whitening register, ROUNDS-1 round cells and a final
//   cell with the output register, which each result passes through in
//   that order.
//   Stall: when m_tvalid is high and m_tready low the whole chain holds and
//   s_tready drops; empty slots do not compress.
//   Reset: config registers and block counter clear to zero, pipeline empties.
module aes128_ctr_block_unit
    import actr_pkg::*;
#(
    parameter int ROUNDS = 10
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // data_high [63:0], data_low [127:64]
    input  logic         s_tuser,   // first_block
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // result_high [63:0], result_low [127:64]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data
);

    typedef enum logic [2:0] {
        REG_KEY_HIGH      = 3'd0,
        REG_KEY_LOW       = 3'd1,
        REG_NONCE_HIGH    = 3'd2,
        REG_NONCE_LOW     = 3'd3,
        REG_COUNTER_START = 3'd4
    } cfg_reg_t;

    logic [63:0]  key_high_reg;
    logic [63:0]  key_low_reg;
    logic [31:0]  nonce_high_reg;
    logic [63:0]  nonce_low_reg;
    logic [31:0]  counter_start_reg;
    logic [31:0]  counter_reg;
    logic [31:0]  counter_use;
    logic         adv;
    logic         accept;
    logic         head_valid_reg;
    stage_t       head_reg;
    stage_t       head_next;
    blk_t         key_blk;
    blk_t         ctr_blk;
    logic [127:0] result;

    logic   chain_valid [ROUNDS];
    stage_t chain_stage [ROUNDS];

    // Global advance: the chain moves whenever the output slot frees up
    assign adv       = !m_tvalid || m_tready;
    assign s_tready  = adv;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg      <= '0;
            key_low_reg       <= '0;
            nonce_high_reg    <= '0;
            nonce_low_reg     <= '0;
            counter_start_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_KEY_HIGH:      key_high_reg      <= cfg_data;
                REG_KEY_LOW:       key_low_reg       <= cfg_data;
                REG_NONCE_HIGH:    nonce_high_reg    <= cfg_data[31:0];
                REG_NONCE_LOW:     nonce_low_reg     <= cfg_data;
                REG_COUNTER_START: counter_start_reg <= cfg_data[31:0];
                default:           ;
            endcase
        end
    end

    // Block counter: reload on first block, wrap modulo 2^32
    assign counter_use = s_tuser ? counter_start_reg : counter_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
        end
        else if (accept)
        begin
            counter_reg <= counter_use + 32'd1;
        end
    end

    // Counter block and initial AddRoundKey
    always_comb
    begin
        key_blk         = {key_high_reg, key_low_reg};
        ctr_blk         = {nonce_high_reg, nonce_low_reg, counter_use};
        head_next.state = ctr_blk ^ key_blk;
        head_next.rkey  = key_blk;
        head_next.rcon  = RCON_FIRST;
        head_next.data  = {s_tdata[63:0], s_tdata[127:64]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            head_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            head_reg <= head_next;
        end
    end

    assign chain_valid[0] = head_valid_reg;
    assign chain_stage[0] = head_reg;

    // Rounds 1 .. ROUNDS-1
    for (genvar i = 1; i < ROUNDS; i++)
    begin : g_round
        actr_round_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (chain_valid[i-1]),
            .in_stage  (chain_stage[i-1]),
            .out_valid (chain_valid[i]),
            .out_stage (chain_stage[i])
        );
    end

    // Final round and output register
    actr_final_cell u_final (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (chain_valid[ROUNDS-1]),
        .in_stage  (chain_stage[ROUNDS-1]),
        .out_valid (m_tvalid),
        .out_data  (result)
    );

    assign m_tdata = {result[63:0], result[127:64]};

endmodule

// File: rtl/actr_checker.sv
// Port-level checks for aes128_ctr_block_unit, attached by bind.
// Depends only on the top level's ports.
module actr_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic         cfg_ready
);

    // A stalled output transfer holds its data
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed while stalled");

    // An empty output slot never blocks the input
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with output empty");

    // A taken output always frees the chain for a new input
    a_take_ready: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready |-> s_tready)
        else $error("input blocked while output drains");

    // Configuration writes are never refused
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config channel not ready");

endmodule

bind aes128_ctr_block_unit actr_checker u_actr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_ready (cfg_ready)
);

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for aes128_ctr_block_unit (AES-128 counter mode).
// Holds its own AES-128 CTR predictor and checks every output transfer in order.
// Depends only on the RTL top level; the S-box is derived here from GF(2^8).
module testbench;

    localparam int AES_ROUNDS  = 10;
    localparam int QUIET_LIMIT = 1000;   // cycles without any transfer
    localparam int TAIL_CYCLES = 30;     // settle time after the last result
    localparam int PRINT_LIMIT = 100;

    localparam logic [7:0] GF_REDUCE   = 8'h1b;
    localparam logic [7:0] SBOX_AFFINE = 8'h63;
    localparam logic [7:0] RCON_INIT   = 8'h01;

    typedef enum logic [2:0] {
        REG_KEY_HIGH,
        REG_KEY_LOW,
        REG_NONCE_HIGH,
        REG_NONCE_LOW,
        REG_COUNTER_START,
        REG_SPARE5,
        REG_SPARE6,
        REG_SPARE7
    } cfg_reg_e;

    // byte 0 in the top bits, byte index = row + 4 * column
    typedef logic [0:15][7:0] aes_state_t;

    typedef struct packed {
        logic [63:0] res_high;
        logic [63:0] res_low;
    } ctr_result_t;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata   = '0;   // data_high [63:0], data_low [127:64]
    logic         s_tuser   = 1'b0; // first_block
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [127:0] m_tdata;          // result_high [63:0], result_low [127:64]
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [63:0]  cfg_data  = '0;

    aes128_ctr_block_unit #(.ROUNDS(AES_ROUNDS)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Predictor state: register copies and the block counter
    logic [63:0] mdl_key_high   = '0;
    logic [63:0] mdl_key_low    = '0;
    logic [31:0] mdl_nonce_high = '0;
    logic [63:0] mdl_nonce_low  = '0;
    logic [31:0] mdl_ctr_start  = '0;
    logic [31:0] blk_ctr        = '0;

    logic [7:0]  sub_tab [0:255];
    ctr_result_t outbound_blocks [$];
    int          err_cnt      = 0;
    int          quiet_cycles = 0;
    int          stall_left   = 0;
    bit          idle_on      = 1'b1;

    //------------------------------------------------------------------
    // AES-128 predictor
    //------------------------------------------------------------------
    function automatic logic [7:0] gf_dbl(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? GF_REDUCE : 8'h00);
    endfunction

    // S-box from multiplicative inverse (via log tables, generator 3) plus affine map
    task automatic build_sub_table();
        logic [7:0] exp_tab [0:255];
        logic [7:0] log_tab [0:255];
        logic [7:0] p;
        logic [7:0] inv;
        p = 8'h01;
        for (int i = 0; i < 255; i++)
        begin
            exp_tab[i] = p;
            log_tab[p] = 8'(i);
            p = p ^ gf_dbl(p);
        end
        for (int x = 0; x < 256; x++)
        begin
            if (x == 0)
                inv = 8'h00;
            else
                inv = exp_tab[(255 - int'(log_tab[x])) % 255];
            sub_tab[x] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                         ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ SBOX_AFFINE;
        end
    endtask

    // SubBytes and ShiftRows together
    function automatic aes_state_t sub_rows(input aes_state_t s);
        aes_state_t t;
        for (int col = 0; col < 4; col++)
            for (int row = 0; row < 4; row++)
                t[4 * col + row] = sub_tab[s[4 * ((col + row) % 4) + row]];
        return t;
    endfunction

    function automatic aes_state_t mix_cols(input aes_state_t s);
        aes_state_t t;
        logic [7:0] b0, b1, b2, b3, all;
        for (int col = 0; col < 4; col++)
        begin
            b0  = s[4 * col];
            b1  = s[4 * col + 1];
            b2  = s[4 * col + 2];
            b3  = s[4 * col + 3];
            all = b0 ^ b1 ^ b2 ^ b3;
            t[4 * col]     = b0 ^ all ^ gf_dbl(b0 ^ b1);
            t[4 * col + 1] = b1 ^ all ^ gf_dbl(b1 ^ b2);
            t[4 * col + 2] = b2 ^ all ^ gf_dbl(b2 ^ b3);
            t[4 * col + 3] = b3 ^ all ^ gf_dbl(b3 ^ b0);
        end
        return t;
    endfunction

    // Key schedule step on 32-bit words, first byte of a word in the top bits
    function automatic aes_state_t next_round_key(input aes_state_t k, input logic [7:0] rc);
        aes_state_t  n;
        logic [31:0] w [4];
        logic [31:0] rot;
        for (int c = 0; c < 4; c++)
            w[c] = {k[4 * c], k[4 * c + 1], k[4 * c + 2], k[4 * c + 3]};
        rot  = {sub_tab[k[13]] ^ rc, sub_tab[k[14]], sub_tab[k[15]], sub_tab[k[12]]};
        w[0] = w[0] ^ rot;
        w[1] = w[1] ^ w[0];
        w[2] = w[2] ^ w[1];
        w[3] = w[3] ^ w[2];
        for (int c = 0; c < 4; c++)
            {n[4 * c], n[4 * c + 1], n[4 * c + 2], n[4 * c + 3]} = w[c];
        return n;
    endfunction

    function automatic aes_state_t aes128_encrypt(input logic [127:0] key,
                                                  input logic [127:0] blk);
        aes_state_t s;
        aes_state_t rk;
        logic [7:0] rc;
        rk = key;
        s  = blk ^ key;
        rc = RCON_INIT;
        for (int r = 1; r <= AES_ROUNDS; r++)
        begin
            s = sub_rows(s);
            if (r != AES_ROUNDS)
                s = mix_cols(s);
            rk = next_round_key(rk, rc);
            rc = gf_dbl(rc);
            s  = s ^ rk;
        end
        return s;
    endfunction

    // One block through the counter-mode transform; advances the counter
    task automatic ctr_encrypt_step(input logic [63:0] dh, input logic [63:0] dl,
                                    input logic first_blk, output ctr_result_t res);
        logic [127:0] ks;
        if (first_blk)
            blk_ctr = mdl_ctr_start;
        ks = aes128_encrypt({mdl_key_high, mdl_key_low},
                            {mdl_nonce_high, mdl_nonce_low, blk_ctr});
        {res.res_high, res.res_low} = {dh, dl} ^ ks;
        blk_ctr = blk_ctr + 32'd1;
    endtask

    task automatic model_reg_write(input cfg_reg_e idx, input logic [63:0] val);
        case (idx)
            REG_KEY_HIGH:      mdl_key_high   = val;
            REG_KEY_LOW:       mdl_key_low    = val;
            REG_NONCE_HIGH:    mdl_nonce_high = val[31:0];
            REG_NONCE_LOW:     mdl_nonce_low  = val;
            REG_COUNTER_START: mdl_ctr_start  = val[31:0];
            default:           ;
        endcase
    endtask

    //------------------------------------------------------------------
    // Checking
    //------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        err_cnt++;
        if (err_cnt <= PRINT_LIMIT)
            $display("ERROR %0t: %s", $time, msg);
    endtask

    // Sampled at the falling edge; the transfer completes on the next rising edge
    always @(negedge clk)
    begin
        ctr_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (outbound_blocks.size() == 0)
                report_mismatch($sformatf("output transfer with nothing pending: %h", m_tdata));
            else
            begin
                want = outbound_blocks.pop_front();
                if (m_tdata[63:0] !== want.res_high)
                    report_mismatch($sformatf("result_high got %h want %h",
                                              m_tdata[63:0], want.res_high));
                if (m_tdata[127:64] !== want.res_low)
                    report_mismatch($sformatf("result_low got %h want %h",
                                              m_tdata[127:64], want.res_low));
            end
        end
    end

    // Watchdog on cycles with no transfer on any channel
    always @(negedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Output back-pressure in random bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 4);
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    //------------------------------------------------------------------
    // Drivers (all called at a rising edge)
    //------------------------------------------------------------------
    // Leaves s_tvalid high after the transfer unless a gap is inserted
    task automatic send_block(input logic [63:0] dh, input logic [63:0] dl,
                              input logic first_blk);
        ctr_result_t res;
        s_tvalid <= 1'b1;
        s_tdata  <= {dl, dh};
        s_tuser  <= first_blk;
        do @(negedge clk); while (!s_tready);
        @(posedge clk);
        ctr_encrypt_step(dh, dl, first_blk, res);
        outbound_blocks.insert(outbound_blocks.size(), res);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // Stop the input stream and wait for every pending result
    task automatic drain_stream();
        s_tvalid <= 1'b0;
        while (outbound_blocks.size() != 0)
            @(posedge clk);
    endtask

    // Leaves cfg_valid high; callers finish a batch with cfg_quiet
    task automatic write_reg(input cfg_reg_e idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        model_reg_write(idx, val);
    endtask

    task automatic cfg_quiet();
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_settings(input logic [63:0] kh, input logic [63:0] kl,
                                 input logic [63:0] nh, input logic [63:0] nl,
                                 input logic [63:0] c0);
        write_reg(REG_KEY_HIGH, kh);
        write_reg(REG_KEY_LOW, kl);
        write_reg(REG_NONCE_HIGH, nh);
        write_reg(REG_NONCE_LOW, nl);
        write_reg(REG_COUNTER_START, c0);
        cfg_quiet();
    endtask

    // Random 64-bit word, sometimes an extreme
    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------
    // Counter runs from its reset value with all-zero key and nonce
    task automatic test_reset_state();
        send_block('0, '0, 1'b0);
        send_block('1, '1, 1'b0);
        send_block(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 1'b0);
        drain_stream();
    endtask

    // Spare indexes are ignored; upper bits of 32-bit registers are dropped
    task automatic test_register_edges();
        write_reg(REG_SPARE5, '1);
        write_reg(REG_SPARE6, '1);
        write_reg(REG_SPARE7, '1);
        write_reg(REG_NONCE_HIGH, 64'hffff_ffff_0123_4567);
        write_reg(REG_COUNTER_START, 64'hdead_beef_0000_0010);
        cfg_quiet();
        send_block(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 1'b1);
        send_block('0, '1, 1'b0);
        drain_stream();
    endtask

    // All-ones settings with counter wrap, then all-zero settings
    task automatic test_extreme_settings();
        load_settings('1, '1, '1, '1, '1);
        send_block('1, '1, 1'b1);
        send_block('0, '0, 1'b0);
        send_block('1, '0, 1'b0);
        drain_stream();
        load_settings('0, '0, '0, '0, '0);
        send_block('0, '1, 1'b1);
        send_block('1, '1, 1'b0);
        drain_stream();
    endtask

    // First-block flag in the middle of a run reloads the counter
    task automatic test_counter_reload();
        load_settings(64'h2b7e_1516_28ae_d2a6, 64'habf7_1588_09cf_4f3c,
                      64'hf0f1_f2f3, 64'hf4f5_f6f7_f8f9_fafb, 64'h0000_0007);
        send_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
        send_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
        send_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
        send_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
        send_block({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
        drain_stream();
    endtask

    // Messages of random length; most start with a first block, some noise
    task automatic stream_messages(input int n_items);
        int sent;
        int msg_len;
        int msg;
        bit first_blk;
        sent = 0;
        msg  = 0;
        while (sent < n_items)
        begin
            msg_len = $urandom_range(1, 12);
            // hold-off until the pipeline is empty
            if (msg == 2)
                drain_stream();
            for (int i = 0; i < msg_len; i++)
            begin
                if (i == 0)
                    first_blk = ($urandom_range(0, 9) != 0);
                else
                    first_blk = ($urandom_range(0, 15) == 0);
                send_block(rand_word(), rand_word(), first_blk);
            end
            sent += msg_len;
            msg++;
        end
    endtask

    task automatic test_random_messages();
        logic [63:0] c0;
        for (int phase = 0; phase < 8; phase++)
        begin
            drain_stream();
            idle_on = ($urandom_range(0, 3) != 0);
            // some phases start close to counter wrap
            if ($urandom_range(0, 2) == 0)
                c0 = {$urandom, 32'hffff_fff0 | 32'($urandom_range(0, 15))};
            else
                c0 = rand_word();
            if ($urandom_range(0, 1) == 0)
                write_reg(cfg_reg_e'($urandom_range(REG_SPARE5, REG_SPARE7)), rand_word());
            load_settings(rand_word(), rand_word(), rand_word(), rand_word(), c0);
            stream_messages(60);
        end
        drain_stream();
    endtask

    // No idling on either side
    task automatic test_back_to_back();
        drain_stream();
        idle_on = 1'b0;
        load_settings(rand_word(), rand_word(), rand_word(), rand_word(),
                      {$urandom, 32'hffff_ffc0});
        stream_messages(120);
        drain_stream();
    endtask

    initial
    begin
        build_sub_table();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_register_edges();
        test_extreme_settings();
        test_counter_reload();
        test_random_messages();
        test_back_to_back();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_cnt == 0 && outbound_blocks.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: aes128_ctr_block_unit.f
rtl/actr_pkg.sv
rtl/actr_round_cell.sv
rtl/actr_final_cell.sv
rtl/aes128_ctr_block_unit.sv
rtl/actr_checker.sv
tb/testbench.sv
